### rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned DelayWidth = 10;
  localparam logic [DelayWidth-1:0] DelayReset = 10'd10;

  // Command codes carried in the func field
  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_STOP  = 2'd1,
    FN_WRITE = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  // One tick of input: command offer plus the sampled SDA level
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } req_t;

  // One tick of output: pin drives and command status
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/i2cm_skid.sv
// Two-entry output register with skid slot for the result channel.
`default_nettype none

module i2cm_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  i2cm_pkg::rsp_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output i2cm_pkg::rsp_t  pop_data
);
  import i2cm_pkg::*;

  logic out_v;
  logic skid_v;
  rsp_t out_d;
  rsp_t skid_d;
  logic push;
  logic pop;

  // Ready comes from a register only, so the sides stay apart
  assign push_ready = !skid_v;
  assign push       = push_valid && push_ready;
  assign pop        = out_v && pop_ready;
  assign pop_valid  = out_v;
  assign pop_data   = out_d;

  // Control: output slot and skid slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (out_v && !pop) begin
        skid_v <= 1'b1;
      end else begin
        out_v <= 1'b1;
      end
    end else if (pop) begin
      out_v <= 1'b0;
    end
  end

  // Payload: move skid beat forward or capture the new beat
  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pop) begin
        out_d <= skid_d;
      end
    end else if (push) begin
      if (out_v && !pop) begin
        skid_d <= push_data;
      end else begin
        out_d <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/i2c_master_byte_engine.sv
// Top level: I2C master bit timing engine, one bus tick per request beat.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------
//   req     | in        | req_valid/req_ready  | i2cm_pkg::req_t
//   rsp     | out       | rsp_valid/rsp_ready  | i2cm_pkg::rsp_t
//   cfg     | in        | cfg_valid/cfg_ready  | delay_ticks [9:0]
//
// Each req beat is one bus tick and yields one rsp beat; one beat per cycle
// sustained while rsp is not stalled, the result leaving through the output register.
// The phase machine updates in the accepting cycle; rsp leaves through a
// two-entry output register, so req_ready drops only when both entries hold.
// rst is synchronous: phase idle, pins released, delay_ticks back to 10.
// A stalled rsp holds its beat; the engine advances only on accepted beats.
`default_nettype none

module i2c_master_byte_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  i2cm_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output i2cm_pkg::rsp_t                     rsp,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i2cm_pkg::DelayWidth-1:0]    cfg_data
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B, PH_SP_C,
    PH_SETUP, PH_HIGH, PH_LOW, PH_TAIL
  } phase_t;

  logic [DelayWidth-1:0] delay_ticks;
  phase_t                phase,       phase_next;
  logic [DelayWidth-1:0] tick_count,  tick_next;
  logic [3:0]            bit_index,   bit_next;
  logic [7:0]            shift_reg,   shift_next;
  func_t                 active_cmd,  cmd_next;
  logic                  ack_choice,  ack_choice_next;
  logic                  scl_drive,   scl_next;
  logic                  sda_drive,   sda_next;
  logic [7:0]            rx_last,     rx_next;
  logic                  ack_last,    ack_last_next;

  logic                  accept;
  rsp_t                  res;
  logic                  busy;
  logic                  done;
  logic                  drive_bit;
  logic                  drive_one;
  logic [DelayWidth-1:0] limit;
  logic [DelayWidth-1:0] tick_inc;
  logic [3:0]            bit_inc;

  assign cfg_ready = 1'b1;
  assign accept    = req_valid && req_ready;
  assign limit     = (delay_ticks == '0) ? DelayWidth'(1) : delay_ticks;

  // Hold the phase timing register
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DelayReset;
    end else if (cfg_valid && cfg_ready) begin
      delay_ticks <= cfg_data;
    end
  end

  // Work out one tick: take a command, apply phase entry, end the phase
  always_comb begin
    phase_next      = phase;
    tick_next       = tick_count;
    bit_next        = bit_index;
    shift_next      = shift_reg;
    cmd_next        = active_cmd;
    ack_choice_next = ack_choice;
    scl_next        = scl_drive;
    sda_next        = sda_drive;
    rx_next         = rx_last;
    ack_last_next   = ack_last;
    done            = 1'b0;
    tick_inc        = '0;
    bit_inc         = '0;

    // Take a new command only when idle
    if (phase == PH_IDLE && req.cmd_valid) begin
      cmd_next        = func_t'(req.func);
      ack_choice_next = req.send_ack;
      bit_next        = '0;
      tick_next       = '0;
      shift_next      = (func_t'(req.func) == FN_WRITE) ? req.tx_byte : 8'd0;
      unique case (func_t'(req.func))
        FN_START: phase_next = PH_ST_A;
        FN_STOP:  phase_next = PH_SP_A;
        FN_WRITE: phase_next = PH_SETUP;
        FN_READ:  phase_next = PH_SETUP;
        default:  phase_next = PH_SETUP;
      endcase
    end

    busy      = (phase_next != PH_IDLE);
    drive_bit = (cmd_next == FN_WRITE) ? (bit_next < 4'd8) : (bit_next == 4'd8);
    drive_one = (cmd_next == FN_WRITE) ? shift_next[7] : !ack_choice_next;

    // Apply pin changes on the first tick of a phase
    if (busy && tick_next == '0) begin
      unique case (phase_next)
        PH_ST_A:  begin scl_next = 1'b0; sda_next = 1'b0; end
        PH_ST_B:  sda_next = 1'b1;
        PH_ST_C:  scl_next = 1'b1;
        PH_SP_A:  begin sda_next = 1'b1; scl_next = 1'b1; end
        PH_SP_B:  scl_next = 1'b0;
        PH_SP_C:  sda_next = 1'b0;
        PH_SETUP: sda_next = drive_bit ? !drive_one : 1'b0;
        PH_HIGH:  scl_next = 1'b0;
        PH_LOW:   scl_next = 1'b1;
        PH_TAIL:  sda_next = 1'b1;
        default:  ;
      endcase
    end

    res.scl_low = scl_next;
    res.sda_low = sda_next;

    // Count the tick and leave the phase at its limit
    if (busy) begin
      tick_inc = tick_next + DelayWidth'(1);
      if (tick_inc >= limit) begin
        tick_next = '0;
        unique case (phase_next)
          PH_ST_A:  phase_next = PH_ST_B;
          PH_ST_B:  phase_next = PH_ST_C;
          PH_SP_A:  phase_next = PH_SP_B;
          PH_SP_B:  phase_next = PH_SP_C;
          PH_SETUP: phase_next = PH_HIGH;
          PH_HIGH: begin
            if (!drive_bit) begin
              if (cmd_next == FN_WRITE) begin
                ack_last_next = req.sda_in;
              end else begin
                shift_next = {shift_next[6:0], req.sda_in};
                if (bit_next == 4'd7) begin
                  rx_next = shift_next;
                end
              end
            end
            phase_next = PH_LOW;
          end
          PH_LOW: begin
            if (drive_bit) begin
              if (drive_one) begin
                sda_next = 1'b1;
              end
              if (cmd_next == FN_WRITE) begin
                shift_next = {shift_next[6:0], 1'b0};
              end
            end
            bit_inc  = bit_next + 4'd1;
            bit_next = bit_inc;
            if (bit_inc <= 4'd8) begin
              phase_next = PH_SETUP;
            end else if (cmd_next == FN_READ) begin
              phase_next = PH_TAIL;
            end else begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        endcase
      end else begin
        tick_next = tick_inc;
      end
    end

    res.busy_res = busy;
    res.done_res = done;
    res.rx_byte  = rx_next;
    res.ack_bit  = ack_last_next;
  end

  // Advance the engine on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_reg  <= '0;
      active_cmd <= FN_START;
      ack_choice <= 1'b0;
      scl_drive  <= 1'b0;
      sda_drive  <= 1'b0;
      rx_last    <= '0;
      ack_last   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      tick_count <= tick_next;
      bit_index  <= bit_next;
      shift_reg  <= shift_next;
      active_cmd <= cmd_next;
      ack_choice <= ack_choice_next;
      scl_drive  <= scl_next;
      sda_drive  <= sda_next;
      rx_last    <= rx_next;
      ack_last   <= ack_last_next;
    end
  end

  // Register the result beat
  i2cm_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (req_valid),
    .push_ready (req_ready),
    .push_data  (res),
    .pop_valid  (rsp_valid),
    .pop_ready  (rsp_ready),
    .pop_data   (rsp)
  );

endmodule

`default_nettype wire

### rtl/i2cm_checker.sv
// Port-level checks for the I2C master byte engine, bound to the top level.
`default_nettype none

module i2cm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input i2cm_pkg::rsp_t                  rsp,
  input logic                            cfg_ready
);
  import i2cm_pkg::*;

  // A completing beat is always a busy beat
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.done_res || rsp.busy_res))
    else $error("done_res without busy_res");

  // Backpressure on req only when a result is already waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("req_ready low with no pending rsp beat");

  // Configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("cfg_ready dropped");

  // A stalled rsp beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp beat changed while stalled");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

### bench/i2cm_tick_checker.sv
// Checker for the I2C byte engine: predicts every bus tick and compares each rsp beat.
module i2cm_tick_checker
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  rsp_t                  rsp,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [DelayWidth-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    BP_IDLE,
    BP_START_A,
    BP_START_B,
    BP_START_C,
    BP_STOP_A,
    BP_STOP_B,
    BP_STOP_C,
    BP_SETUP,
    BP_HIGH,
    BP_LOW,
    BP_TAIL
  } bus_phase_t;

  // Predicted engine state
  logic [DelayWidth-1:0] delay_cfg;
  bus_phase_t            phase;
  logic [9:0]            tick_cnt;
  logic [3:0]            bit_idx;
  logic [7:0]            shreg;
  func_t                 cur_cmd;
  logic                  ack_sel;
  logic                  scl_drv;
  logic                  sda_drv;
  logic [7:0]            last_rx;
  logic                  last_ack;

  rsp_t expected_ticks[$];
  rsp_t want;
  int   fails = 0;
  int   depth = 0;

  assign fail_count = fails;
  assign pending    = depth;

  // True when the master owns SDA for the current bit
  function automatic logic master_owns_bit();
    if (cur_cmd == FN_WRITE) return bit_idx < 4'd8;
    return bit_idx == 4'd8;
  endfunction

  // Level the master puts on an owned bit: data MSB on write, ack/nack on read
  function automatic logic owned_level();
    if (cur_cmd == FN_WRITE) return shreg[7];
    return !ack_sel;
  endfunction

  // Apply the pin changes that take effect on the first tick of a phase
  function automatic void open_phase();
    case (phase)
      BP_START_A: begin
        scl_drv = 1'b0;
        sda_drv = 1'b0;
      end
      BP_START_B: sda_drv = 1'b1;
      BP_START_C: scl_drv = 1'b1;
      BP_STOP_A: begin
        sda_drv = 1'b1;
        scl_drv = 1'b1;
      end
      BP_STOP_B:  scl_drv = 1'b0;
      BP_STOP_C:  sda_drv = 1'b0;
      BP_SETUP:   sda_drv = master_owns_bit() ? !owned_level() : 1'b0;
      BP_HIGH:    scl_drv = 1'b0;
      BP_LOW:     scl_drv = 1'b1;
      BP_TAIL:    sda_drv = 1'b1;
      default: ;
    endcase
  endfunction

  // Advance past the current phase; returns 1 when the command finishes
  function automatic logic close_phase(input logic sda);
    logic fin;
    fin = 1'b0;
    case (phase)
      BP_START_A: phase = BP_START_B;
      BP_START_B: phase = BP_START_C;
      BP_STOP_A:  phase = BP_STOP_B;
      BP_STOP_B:  phase = BP_STOP_C;
      BP_SETUP:   phase = BP_HIGH;
      BP_HIGH: begin
        // sample the slave's bit as SCL high ends
        if (!master_owns_bit()) begin
          if (cur_cmd == FN_WRITE) begin
            last_ack = sda;
          end else begin
            shreg = {shreg[6:0], sda};
            if (bit_idx == 4'd7) last_rx = shreg;
          end
        end
        phase = BP_LOW;
      end
      BP_LOW: begin
        // a written one pulls SDA low again; shift the next data bit up
        if (master_owns_bit()) begin
          if (owned_level()) sda_drv = 1'b1;
          if (cur_cmd == FN_WRITE) shreg = shreg << 1;
        end
        bit_idx = bit_idx + 4'd1;
        if (bit_idx <= 4'd8) begin
          phase = BP_SETUP;
        end else if (cur_cmd == FN_READ) begin
          phase = BP_TAIL;
        end else begin
          phase = BP_IDLE;
          fin = 1'b1;
        end
      end
      default: begin
        phase = BP_IDLE;
        fin = 1'b1;
      end
    endcase
    return fin;
  endfunction

  // Work out the rsp beat that one accepted req beat produces
  function automatic rsp_t predict_bus_tick(input req_t r);
    rsp_t       o;
    logic [9:0] lim;
    lim = (delay_cfg == '0) ? 10'd1 : delay_cfg;
    o = '0;
    if (phase == BP_IDLE && r.cmd_valid) begin
      cur_cmd  = func_t'(r.func);
      ack_sel  = r.send_ack;
      bit_idx  = '0;
      tick_cnt = '0;
      shreg    = (cur_cmd == FN_WRITE) ? r.tx_byte : 8'h00;
      case (cur_cmd)
        FN_START: phase = BP_START_A;
        FN_STOP:  phase = BP_STOP_A;
        default:  phase = BP_SETUP;
      endcase
    end
    if (phase != BP_IDLE) begin
      o.busy_res = 1'b1;
      if (tick_cnt == '0) open_phase();
    end
    o.scl_low = scl_drv;
    o.sda_low = sda_drv;
    if (phase != BP_IDLE) begin
      tick_cnt = tick_cnt + 10'd1;
      if (tick_cnt >= lim) begin
        tick_cnt   = '0;
        o.done_res = close_phase(r.sda_in);
      end
    end
    o.rx_byte = last_rx;
    o.ack_bit = last_ack;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  // Track config, queue predictions on req beats, compare on rsp beats
  always @(posedge clk) begin
    if (rst) begin
      delay_cfg = DelayReset;
      phase     = BP_IDLE;
      tick_cnt  = '0;
      bit_idx   = '0;
      shreg     = '0;
      cur_cmd   = FN_START;
      ack_sel   = 1'b0;
      scl_drv   = 1'b0;
      sda_drv   = 1'b0;
      last_rx   = '0;
      last_ack  = 1'b0;
      expected_ticks.delete();
    end else begin
      // a req beat taken at the same edge as a config write sees the old delay
      if (req_valid && req_ready) expected_ticks.push_back(predict_bus_tick(req));
      if (cfg_valid && cfg_ready) delay_cfg = cfg_data;
      if (rsp_valid && rsp_ready) begin
        if (expected_ticks.size() == 0) begin
          $error("rsp beat arrived with no tick outstanding");
          fails++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("scl_low", 8'(want.scl_low), 8'(rsp.scl_low));
          check_field("sda_low", 8'(want.sda_low), 8'(rsp.sda_low));
          check_field("busy_res", 8'(want.busy_res), 8'(rsp.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
          check_field("rx_byte", want.rx_byte, rsp.rx_byte);
          check_field("ack_bit", 8'(want.ack_bit), 8'(rsp.ack_bit));
        end
      end
    end
    depth <= expected_ticks.size();
  end

endmodule

### bench/tb_top.sv
// Testbench top: clock, reset, bus-tick stimulus and verdict for the I2C byte engine.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  localparam int PhaseBeats = 170;
  localparam int LongHold   = 200;
  localparam int NumPhases  = 6;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req       = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [DelayWidth-1:0] cfg_data  = '0;
  int                    fail_count;
  int                    pending;

  // Traffic shaping
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_kick    = 1'b0;
  logic hold_seen    = 1'b0;
  int   hold_left    = 0;
  int   cur_delay    = DelayReset;
  int   beats        = 0;

  // Per-phase idling and delay
  int ph_tx_idle[NumPhases]  = '{0, 86, 0, 14, 0, 14};
  int ph_rx_stall[NumPhases] = '{0, 0, 86, 14, 0, 14};
  int ph_delay[NumPhases]    = '{1, 2, 1, 3, 1, 0};

  always #4 clk = ~clk;

  i2c_master_byte_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  i2cm_tick_checker tick_chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: random stalls, plus a long hold-off whenever hold_kick toggles
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= LongHold;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Ticks a command occupies at the current delay
  function automatic int cmd_ticks(input func_t f);
    int d;
    d = (cur_delay == 0) ? 1 : cur_delay;
    case (f)
      FN_START, FN_STOP: return 3 * d;
      FN_WRITE:          return 27 * d;
      default:           return 28 * d;
    endcase
  endfunction

  function automatic req_t rand_req(input logic offer);
    req_t r;
    r.cmd_valid = offer;
    r.func      = 2'($urandom_range(3));
    r.tx_byte   = 8'($urandom);
    r.send_ack  = 1'($urandom);
    r.sda_in    = 1'($urandom);
    return r;
  endfunction

  // Offer one tick, idling first at the current rate, and hold until taken
  task automatic send_beat(input req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    beats++;
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_beat(rand_req(1'b0));
  endtask

  // Issue a command and feed ticks until it completes; busy_offer_pct sets how
  // often a command is offered while busy, sda_lvl < 0 means random SDA
  task automatic run_cmd(input func_t f, input logic [7:0] tx, input logic ack,
                         input int busy_offer_pct, input int sda_lvl);
    req_t r;
    int   n;
    n = cmd_ticks(f);
    for (int k = 0; k < n; k++) begin
      r = rand_req(k == 0 || $urandom_range(99) < busy_offer_pct);
      if (k == 0) begin
        r.func     = f;
        r.tx_byte  = tx;
        r.send_ack = ack;
      end
      if (sda_lvl >= 0) r.sda_in = sda_lvl[0];
      send_beat(r);
    end
  endtask

  // Stop offering until every predicted tick has come back
  task automatic wait_all_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_delay(input logic [DelayWidth-1:0] v);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_delay = v;
  endtask

  // One bus transaction: start, address, a few data bytes, stop; sometimes a
  // stray command or a missing stop instead
  task automatic run_sequence(input int noise_pct);
    int nb;
    idle_ticks($urandom_range(3));
    if ($urandom_range(99) < noise_pct) begin
      run_cmd(func_t'($urandom_range(3)), 8'($urandom), 1'($urandom), 30, -1);
      return;
    end
    nb = $urandom_range(3, 1);
    run_cmd(FN_START, 8'($urandom), 1'($urandom), 20, -1);
    run_cmd(FN_WRITE, 8'($urandom), 1'($urandom), 20, -1);
    repeat (nb) begin
      if ($urandom_range(1) == 0) begin
        run_cmd(FN_WRITE, 8'($urandom), 1'($urandom), 20, -1);
      end else begin
        run_cmd(FN_READ, 8'($urandom), 1'($urandom), 20, -1);
      end
    end
    if ($urandom_range(9) != 0) run_cmd(FN_STOP, 8'($urandom), 1'($urandom), 20, -1);
  endtask

  // Watchdog
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    req_t r;
    int   first;
    logic paused;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset delay, byte extremes, ack and nack, ignored offers
    run_cmd(FN_START, 8'h00, 1'b0, 0, -1);
    idle_ticks(2);
    set_delay(10'd1);
    run_cmd(FN_WRITE, 8'hFF, 1'b1, 0, 0);
    run_cmd(FN_WRITE, 8'h00, 1'b0, 0, 1);
    run_cmd(FN_WRITE, 8'hA5, 1'b0, 0, -1);
    run_cmd(FN_READ, 8'h00, 1'b1, 0, 1);
    run_cmd(FN_READ, 8'hFF, 1'b0, 0, 0);
    run_cmd(FN_READ, 8'h5A, 1'b1, 100, -1);
    run_cmd(FN_STOP, 8'h00, 1'b0, 100, -1);
    idle_ticks(3);

    // Zero delay behaves as one tick per phase
    set_delay(10'd0);
    run_cmd(FN_START, 8'h00, 1'b0, 0, -1);
    run_cmd(FN_WRITE, 8'h81, 1'b0, 0, -1);
    run_cmd(FN_STOP, 8'h00, 1'b0, 0, -1);

    // Longest delay, then shorten it while the first start phase is still under way
    set_delay(10'd1023);
    r = rand_req(1'b1);
    r.func = FN_START;
    send_beat(r);
    idle_ticks(40);
    set_delay(10'd2);
    idle_ticks(8);

    // Random transactions across idling phases
    for (int p = 0; p < NumPhases; p++) begin
      set_delay(ph_delay[p][DelayWidth-1:0]);
      tx_idle_pct = ph_tx_idle[p];
      rx_stall_pct <= ph_rx_stall[p];
      if (p == 0) hold_kick <= ~hold_kick;
      first  = beats;
      paused = 1'b0;
      while (beats - first < PhaseBeats) begin
        if (!paused && beats - first >= PhaseBeats / 2) begin
          wait_all_results();
          paused = 1'b1;
        end
        run_sequence(10);
      end
    end

    // Drain and give the verdict
    wait_all_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/i2cm_pkg.sv
rtl/i2cm_skid.sv
rtl/i2c_master_byte_engine.sv
rtl/i2cm_checker.sv
bench/i2cm_tick_checker.sv
bench/tb_top.sv
